// ----- src/poi_pkg.sv -----
// poi_pkg: shared types, codes and constants of the planar odometry integrator.
// No dependencies; every other file in src imports it.
package poi_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = 5;
    localparam int CNT_W        = $clog2(CORDIC_STEPS) + 1;
    localparam int ACC_W        = 118;

    // 2^64 / (2*pi), split into 32-bit halves
    localparam logic [31:0] INV_2PI_LO = 32'h9391054A;
    localparam logic [31:0] INV_2PI_HI = 32'h28BE60DB;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // atan(2^-i) as binary angle
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    localparam logic [1:0] MODE_INTEGRATE = 2'd0;
    localparam logic [1:0] MODE_LOAD      = 2'd1;
    localparam logic [1:0] MODE_ZERO      = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_MUL_DIST = 4'd2;
    localparam t_op OP_MUL_TURN = 4'd3;
    localparam t_op OP_T00      = 4'd4;
    localparam t_op OP_T01      = 4'd5;
    localparam t_op OP_T10      = 4'd6;
    localparam t_op OP_T11      = 4'd7;
    localparam t_op OP_ANGLE    = 4'd8;
    localparam t_op OP_CORDIC   = 4'd9;
    localparam t_op OP_X0       = 4'd10;
    localparam t_op OP_X1       = 4'd11;
    localparam t_op OP_Y0       = 4'd12;
    localparam t_op OP_Y1       = 4'd13;
    localparam t_op OP_UPDATE   = 4'd14;

    typedef struct packed {
        t_op               op;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic integrate;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
        logic [31:0]        step_time;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [31:0]        new_heading;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic               method_used;
        logic signed [31:0] lin_vel_echo;
        logic signed [31:0] ang_vel_echo;
    } t_out_beat;

endpackage

// ----- src/poi_ifs.sv -----
// poi_ifs: valid/ready channel interfaces for command beats and pose beats.
// Depends on poi_pkg.
interface poi_in_if;
    import poi_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface poi_out_if;
    import poi_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/poi_ctrl.sv -----
// poi_ctrl: sequencer that steps the datapath through one item.
// Depends on poi_pkg.
module poi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  poi_pkg::t_status  i_status,
    output poi_pkg::t_cmd     o_cmd
);
    import poi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_CORD = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_cmd.iter = r_cnt[ITER_W-1:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PRE;
                    n_cnt    = '0;
                end
            end
            S_PRE: begin
                if (!i_status.integrate) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    // gaps let the product land before it is used
                    unique case (r_cnt)
                        CNT_W'(0): o_cmd.op = OP_MUL_DIST;
                        CNT_W'(1): o_cmd.op = OP_MUL_TURN;
                        CNT_W'(3): o_cmd.op = OP_T00;
                        CNT_W'(4): o_cmd.op = OP_T01;
                        CNT_W'(5): o_cmd.op = OP_T10;
                        CNT_W'(6): o_cmd.op = OP_T11;
                        CNT_W'(8): begin
                            o_cmd.op = OP_ANGLE;
                            n_state  = S_CORD;
                            n_cnt    = '0;
                        end
                        default: o_cmd.op = OP_NONE;
                    endcase
                end
            end
            S_CORD: begin
                o_cmd.op = OP_CORDIC;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_POST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_POST: begin
                n_cnt = r_cnt + 1'b1;
                unique case (r_cnt)
                    CNT_W'(0): o_cmd.op = OP_X0;
                    CNT_W'(1): o_cmd.op = OP_X1;
                    CNT_W'(2): o_cmd.op = OP_Y0;
                    CNT_W'(3): o_cmd.op = OP_Y1;
                    CNT_W'(4): n_state  = S_FIN;
                    default:   o_cmd.op = OP_NONE;
                endcase
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_UPDATE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PRE))
        else $error("accepted beat did not start the sequence");
    a_cord_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_cnt < CNT_W'(CORDIC_STEPS)))
        else $error("cordic iteration count out of range");
`endif

endmodule

// ----- src/poi_dp.sv -----
// poi_dp: pose datapath: shared 33x33 multiplier, accumulator, CORDIC, pose registers.
// Depends on poi_pkg.
module poi_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  poi_pkg::t_cmd       i_cmd,
    output poi_pkg::t_status    o_status,
    input  poi_pkg::t_in_beat   i_in_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output poi_pkg::t_out_beat  o_out_data
);
    import poi_pkg::*;

    localparam logic signed [64:0] POS_MAX = 65'sd2147483647;
    localparam logic signed [64:0] POS_MIN = -65'sd2147483648;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [63:0] d);
        logic signed [64:0] s;
        s = 65'(p) + 65'(d);
        if (s > POS_MAX) return 32'sh7FFFFFFF;
        if (s < POS_MIN) return 32'sh80000000;
        return s[31:0];
    endfunction

    logic               r_method;
    logic [1:0]         r_mode;
    logic signed [31:0] r_lin, r_ang;
    logic [31:0]        r_t, r_nx, r_ny, r_nh;
    logic signed [63:0] r_dist, r_turn, r_dx;
    logic signed [65:0] r_pp;
    t_op                r_pp_op;
    logic [ACC_W-1:0]   r_acc;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip, r_used;
    logic [31:0]        r_dh;
    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_hd;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [33:0] trig_c, trig_s;
    logic [ACC_W-1:0]   pp_ext;
    logic [31:0]        ref_ang, fold_ang;
    logic               flip;
    logic signed [33:0] sh_x, sh_y, atan_v;
    logic signed [31:0] n_px, n_py;
    logic [31:0]        n_hd;

    assign trig_c = r_flip ? -r_cx : r_cx;
    assign trig_s = r_flip ? -r_cy : r_cy;

    // upper halves of distance and turn are signed, lower halves unsigned
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_DIST: begin mul_a = 33'(r_lin); mul_b = {1'b0, r_t}; end
            OP_MUL_TURN: begin mul_a = 33'(r_ang); mul_b = {1'b0, r_t}; end
            OP_T00: begin mul_a = {1'b0, r_turn[31:0]}; mul_b = {1'b0, INV_2PI_LO}; end
            OP_T01: begin mul_a = {1'b0, r_turn[31:0]}; mul_b = {1'b0, INV_2PI_HI}; end
            OP_T10: begin mul_a = {r_turn[63], r_turn[63:32]}; mul_b = {1'b0, INV_2PI_LO}; end
            OP_T11: begin mul_a = {r_turn[63], r_turn[63:32]}; mul_b = {1'b0, INV_2PI_HI}; end
            OP_X0: begin mul_a = {1'b0, r_dist[31:0]}; mul_b = trig_c[32:0]; end
            OP_X1: begin mul_a = {r_dist[63], r_dist[63:32]}; mul_b = trig_c[32:0]; end
            OP_Y0: begin mul_a = {1'b0, r_dist[31:0]}; mul_b = trig_s[32:0]; end
            OP_Y1: begin mul_a = {r_dist[63], r_dist[63:32]}; mul_b = trig_s[32:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign pp_ext = {{(ACC_W-66){r_pp[65]}}, r_pp};

    // midpoint heading uses half of this step's turn
    assign ref_ang  = r_method ? (r_hd + r_acc[104:73]) : r_hd;
    assign flip     = ref_ang[31] ^ ref_ang[30];
    assign fold_ang = flip ? {~ref_ang[31], ref_ang[30:0]} : ref_ang;

    assign sh_x   = r_cx >>> i_cmd.iter;
    assign sh_y   = r_cy >>> i_cmd.iter;
    assign atan_v = {2'b00, ATAN_TAB[i_cmd.iter]};

    always_comb begin
        n_px = r_px;
        n_py = r_py;
        n_hd = r_hd;
        unique case (r_mode)
            MODE_INTEGRATE: begin
                n_px = sat_add(r_px, r_dx);
                n_py = sat_add(r_py, r_acc[117:54]);
                n_hd = r_hd + r_dh;
            end
            MODE_LOAD: begin
                n_px = r_nx;
                n_py = r_ny;
                n_hd = r_nh;
            end
            MODE_ZERO: begin
                n_px = '0;
                n_py = '0;
                n_hd = '0;
            end
            default: begin
                n_px = r_px;
                n_py = r_py;
                n_hd = r_hd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pp    <= mul_p;
        r_pp_op <= i_cmd.op;

        if (i_cmd.op == OP_LOAD) begin
            r_mode <= i_in_data.mode;
            r_lin  <= i_in_data.lin_vel;
            r_ang  <= i_in_data.ang_vel;
            r_t    <= i_in_data.step_time;
            r_nx   <= i_in_data.new_x;
            r_ny   <= i_in_data.new_y;
            r_nh   <= i_in_data.new_heading;
        end

        unique case (r_pp_op)
            OP_MUL_DIST: r_dist <= r_pp[63:0];
            OP_MUL_TURN: r_turn <= r_pp[63:0];
            OP_T00, OP_X0: r_acc <= pp_ext;
            OP_T01, OP_T10, OP_X1, OP_Y1: r_acc <= r_acc + (pp_ext << 32);
            OP_T11: r_acc <= r_acc + (pp_ext << 64);
            OP_Y0: begin
                r_dx  <= r_acc[117:54];
                r_acc <= pp_ext;
            end
            default: r_acc <= r_acc;
        endcase

        if (i_cmd.op == OP_ANGLE) begin
            r_dh   <= r_acc[103:72];
            r_used <= r_method;
            r_flip <= flip;
            r_cz   <= 34'(signed'(fold_ang));
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
        end else if (i_cmd.op == OP_CORDIC) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_cz <= r_cz + atan_v;
            end
        end

        if (i_cmd.op == OP_UPDATE) begin
            r_out.pos_x        <= n_px;
            r_out.pos_y        <= n_py;
            r_out.heading      <= n_hd;
            r_out.method_used  <= (r_mode == MODE_INTEGRATE) ? r_used : 1'b0;
            r_out.lin_vel_echo <= (r_mode == MODE_INTEGRATE) ? r_lin : 32'sd0;
            r_out.ang_vel_echo <= (r_mode == MODE_INTEGRATE) ? r_ang : 32'sd0;
        end

        if (!i_rst_n) begin
            r_method    <= 1'b1;
            r_px        <= '0;
            r_py        <= '0;
            r_hd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_method <= i_cfg_wr_data;
            end
            if (i_cmd.op == OP_UPDATE) begin
                r_px        <= n_px;
                r_py        <= n_py;
                r_hd        <= n_hd;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.integrate = (r_mode == MODE_INTEGRATE);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

`ifndef SYNTH
    a_update_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_UPDATE) |-> (!r_out_valid || i_out_ready))
        else $error("pose update would overwrite an untaken beat");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_UPDATE))
        else $error("output beat raised without a pose update");
`endif

endmodule

// ----- src/planar_odometry_integrator.sv -----
// Planar pose integrator. An integrate beat goes from acceptance to the result
// register through two products for distance and turn, four partial products
// for the heading step on the shared 33x33 multiplier, one CORDIC iteration per
// cycle, and four partial products for the x and y steps. Set-pose, clear and
// unused-mode beats skip these steps. One beat is in work at a time; the next is
// accepted once the previous result sits in the output register, even if it is
// not yet taken.
// planar_odometry_integrator: top level, joins poi_ctrl and poi_dp.
// Depends on poi_pkg, poi_ifs, poi_ctrl, poi_dp.
module planar_odometry_integrator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    poi_in_if.sink        i_cmd,
    poi_out_if.source     o_pose,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data
);
    import poi_pkg::*;

    t_cmd    cmd;
    t_status status;

    poi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    poi_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_data     (i_cmd.data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_pose.valid),
        .i_out_ready   (o_pose.ready),
        .o_out_data    (o_pose.data)
    );

endmodule

// ----- tb/sv/tb_poi_ifs_note.sv -----
// tb_poi_ifs_note: small helper package for the pose integrator testbench.
// Holds the pose predictor arithmetic; depends on poi_pkg for field types and constants.
package tb_poi_pred_pkg;
    import poi_pkg::*;

    localparam logic [63:0] INV_TWO_PI = {INV_2PI_HI, INV_2PI_LO};
    localparam logic signed [63:0] GAIN_Q30 = 64'sh26DD3B6A;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        yaw;
    } t_pose;

    // rotation-mode sin/cos with half-turn folding, floor shifts
    function automatic void cordic_sincos(input logic [31:0] ang, input int steps,
                                          output logic signed [63:0] c,
                                          output logic signed [63:0] s);
        logic [31:0] a;
        logic flip;
        logic signed [63:0] x, y, z, dx, dy;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a + 32'h80000000;
        x = GAIN_Q30;
        y = 0;
        z = {{32{a[31]}}, a};
        for (int i = 0; i < steps && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, ATAN_TAB[i]});
            end else begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, ATAN_TAB[i]});
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [31:0] move_sat(logic signed [31:0] pos,
                                                   logic signed [63:0] travel,
                                                   logic signed [63:0] trig);
        logic signed [127:0] p;
        logic signed [63:0] d;
        logic signed [65:0] sum;
        p = travel * trig;
        d = p[117:54];
        sum = pos + d;
        if (sum > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (sum < -66'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_out_beat pose_step(inout t_pose st, input logic method,
                                            input t_in_beat b);
        t_out_beat r;
        logic signed [63:0] travel, turn, c, s;
        logic signed [127:0] hp;
        logic [31:0] dh, half, ref_ang;
        r = '0;
        if (b.mode == MODE_INTEGRATE) begin
            travel = b.lin_vel * $signed({32'd0, b.step_time});
            turn = b.ang_vel * $signed({32'd0, b.step_time});
            hp = turn * $signed({64'd0, INV_TWO_PI});
            dh = hp[103:72];
            half = hp[104:73];
            ref_ang = method ? st.yaw + half : st.yaw;
            cordic_sincos(ref_ang, CORDIC_STEPS, c, s);
            st.x = move_sat(st.x, travel, c);
            st.y = move_sat(st.y, travel, s);
            st.yaw = st.yaw + dh;
            r.method_used = method;
            r.lin_vel_echo = b.lin_vel;
            r.ang_vel_echo = b.ang_vel;
        end else if (b.mode == MODE_LOAD) begin
            st.x = b.new_x; st.y = b.new_y; st.yaw = b.new_heading;
        end else if (b.mode == MODE_ZERO) begin
            st.x = 0; st.y = 0; st.yaw = 0;
        end
        r.pos_x = st.x;
        r.pos_y = st.y;
        r.heading = st.yaw;
        return r;
    endfunction
endpackage

// ----- tb/sv/tb_planar_odometry_integrator.sv -----
// tb_planar_odometry_integrator: self-checking bench for the pose integrator.
// Directed table then random beats, all checked against an in-bench pose predictor.
// Depends on poi_pkg, poi_ifs, tb_poi_pred_pkg and the RTL.
module tb_planar_odometry_integrator;
    timeunit 1ns;
    timeprecision 1ps;
    import poi_pkg::*;
    import tb_poi_pred_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int N_RAND = 1530;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;

    poi_in_if  cmd_ch();
    poi_out_if pose_ch();

    always #2 i_clk = ~i_clk;

    planar_odometry_integrator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch.sink),
        .o_pose       (pose_ch.source),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    typedef struct {
        t_in_beat  b;
        logic      has_fixed;
        t_out_beat fixed;
    } t_row;

    t_out_beat pose_due[$];
    t_pose     pred_pose;
    logic      method_reg;
    int        errors = 0;
    int        beats_sent = 0;
    int        poses_seen = 0;
    int        in_idle_pct = 19;
    int        out_idle_pct = 83;
    int        hold_cycles = 0;
    int        quiet_cycles = 0;
    t_row      table_rows[$];

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        pose_ch.ready = 1'b0;
    end

    // receiver side: random ready, with optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pose_ch.ready <= 1'b0;
        end else begin
            pose_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // compare each accepted pose beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
            poses_seen++;
            if (pose_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected pose beat, actual %p", $time, pose_ch.data);
            end else begin
                e = pose_due.pop_front();
                if (pose_ch.data !== e) begin
                    errors++;
                    $display("%0t: pose mismatch expected %p actual %p", $time, e,
                             pose_ch.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid drops after each beat; the block is busy then anyway
    task automatic send_beat(input t_in_beat b, input logic has_fixed, input t_out_beat fx);
        t_out_beat p;
        while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        p = pose_step(pred_pose, method_reg, b);
        if (has_fixed && p !== fx) begin
            errors++;
            $display("%0t: table row expected %p predicted %p", $time, fx, p);
        end
        pose_due = {pose_due, (has_fixed ? fx : p)};
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= b;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        beats_sent++;
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_and_set(input logic m);
        while (pose_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        method_reg = m;
    endtask

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        int k;
        b.lin_vel = $urandom;
        b.ang_vel = $urandom;
        b.step_time = $urandom;
        b.new_x = $urandom;
        b.new_y = $urandom;
        b.new_heading = $urandom;
        k = $urandom_range(99);
        b.mode = (k < 75) ? MODE_INTEGRATE : (k < 88) ? MODE_LOAD :
                 (k < 95) ? MODE_ZERO : MODE_UNUSED;
        // half the beats get realistic speeds or short steps so poses stay in range
        case ($urandom_range(3))
            0: begin
                b.lin_vel = $signed($urandom_range(32'h00060000)) - 32'sh00030000;
                b.ang_vel = $signed($urandom_range(32'h00080000)) - 32'sh00040000;
                b.step_time = $urandom_range(32'h01000000);
            end
            1: b.step_time = $urandom_range(32'h00001000);
            default: ;
        endcase
        return b;
    endfunction

    function automatic t_row mk(logic [1:0] md, logic [31:0] lv, logic [31:0] av,
                                logic [31:0] st, logic [31:0] nx, logic [31:0] ny,
                                logic [31:0] nh, logic hf, logic [31:0] ex,
                                logic [31:0] ey, logic [31:0] eh);
        t_row r;
        r.b = '{md, lv, av, st, nx, ny, nh};
        r.has_fixed = hf;
        r.fixed = '{ex, ey, eh, 1'b0, 32'd0, 32'd0};
        return r;
    endfunction

    initial begin
        t_in_beat b;
        pred_pose = '{0, 0, 0};
        method_reg = 1'b1;
        // directed table
        table_rows = {table_rows, mk(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0)};
        // zero time
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0,
                                     0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_LOAD, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                                     32'hFFFFFFFF, 1, 32'h7FFFFFFF, 32'h80000000,
                                     32'hFFFFFFFF)};
        // saturation, wrap
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                                     0, 0, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'h80000000, 32'h80000000, 32'hFFFFFFFF,
                                     0, 0, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_UNUSED, 32'hFFFFFFFF, 1, 2, 3, 4, 5, 0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_ZERO, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_LOAD, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                                     32'h40000000, 1, 32'h80000000, 32'h7FFFFFFF,
                                     32'h40000000)};
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'h00010000, 32'h00010000, 32'h01000000,
                                     0, 0, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_LOAD, 0, 0, 0, 0, 0, 32'h80000000, 1, 0, 0,
                                     32'h80000000)};
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'hFFFF0000, 32'h00000001, 32'h01000000,
                                     0, 0, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, mk(MODE_LOAD, 0, 0, 0, 0, 0, 32'hC0000000, 1, 0, 0,
                                     32'hC0000000)};
        table_rows = {table_rows, mk(MODE_INTEGRATE, 32'h00020000, 32'hFFFE0000, 32'h00800000,
                                     0, 0, 0, 0, 0, 0, 0)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            if (i == 9) drain_and_set(1'b0);
            send_beat(table_rows[i].b, table_rows[i].has_fixed, table_rows[i].fixed);
        end
        drain_and_set(1'b1);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 3) begin
                in_idle_pct = 83; out_idle_pct = 19;
                drain_and_set(1'b0);
            end
            if (n == 2 * N_RAND / 3) begin
                in_idle_pct = 0; out_idle_pct = 0;
                drain_and_set(1'b1);
                hold_cycles = 400;     // block fills and stalls the input
            end
            if (n == 5 * N_RAND / 6) drain_and_set(1'($urandom_range(1)));
            b = rand_beat();
            send_beat(b, 1'b0, '0);
        end

        while (pose_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d command beats and %0d pose beats over Euler and midpoint",
                 beats_sent, poses_seen);
        $display("methods, with load, clear, unused mode, saturation and stalls.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
